FILE: design/surt_pkg.sv
package surt_pkg;

  localparam int CAPACITY   = 16;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int KEY_W      = 32;
  localparam int TAG_W      = 64;
  localparam int RANK_W     = 5;
  localparam int CMP_W      = (RANK_W > CNT_W) ? RANK_W : CNT_W;
  localparam logic [RANK_W-1:0] RANK_RESET = RANK_W'(2);

  typedef enum logic [1:0] {
    STATUS_INSERTED  = 2'd0,
    STATUS_DUPLICATE = 2'd1,
    STATUS_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_REPORT
  } state_e;

  typedef struct packed {
    logic load_in;
    logic insert;
    logic load_res;
  } cmd_t;

endpackage

FILE: design/surt_ctrl.sv
module surt_ctrl
  import surt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  output logic done_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_INSERT;
      end
      ST_INSERT: state_d = ST_REPORT;
      ST_REPORT: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    busy_o         = 1'b1;
    done_d         = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy_o        = 1'b0;
        cmd_o.load_in = start_i;
      end
      ST_INSERT: cmd_o.insert = 1'b1;
      ST_REPORT: begin
        cmd_o.load_res = 1'b1;
        done_d         = 1'b1;
      end
      default: busy_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign done_o = done_q;

endmodule

FILE: design/surt_dp.sv
module surt_dp
  import surt_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  input  logic signed [KEY_W-1:0] key_i,
  input  logic [TAG_W-1:0]        entry_tag_i,
  input  logic                    cfg_we_i,
  input  logic [RANK_W-1:0]       cfg_data_i,
  output logic [1:0]              status_o,
  output logic [CNT_W-1:0]        entry_count_o,
  output logic                    winner_valid_o,
  output logic signed [KEY_W-1:0] winner_key_o,
  output logic [TAG_W-1:0]        winner_tag_o
);

  logic signed [KEY_W-1:0] keys_q [CAPACITY];
  logic [TAG_W-1:0]        tags_q [CAPACITY];
  logic [CNT_W-1:0]        cnt_q;
  logic [RANK_W-1:0]       rank_q;
  logic signed [KEY_W-1:0] in_key_q;
  logic [TAG_W-1:0]        in_tag_q;

  status_e                 status_q, status_d;
  logic [CNT_W-1:0]        res_cnt_q;
  logic                    res_valid_q;
  logic signed [KEY_W-1:0] res_key_q;
  logic [TAG_W-1:0]        res_tag_q;

  logic [CAPACITY-1:0]     gt;
  logic [CAPACITY-1:0]     eq;
  logic                    full;
  logic                    do_ins;
  logic [RANK_W-1:0]       rank_eff;
  logic [IDX_W-1:0]        rank_idx;
  logic                    win_ok;

  // per-cell compare against the held key
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      gt[i] = (cnt_q > CNT_W'(i)) && (keys_q[i] > in_key_q);
      eq[i] = (cnt_q > CNT_W'(i)) && (keys_q[i] == in_key_q);
    end
  end

  assign full   = (cnt_q == CNT_W'(CAPACITY));
  assign do_ins = !(|eq) && !full;

  always_comb begin
    if (|eq)       status_d = STATUS_DUPLICATE;
    else if (full) status_d = STATUS_FULL;
    else           status_d = STATUS_INSERTED;
  end

  // cells hold while larger, take the new entry at the boundary, else shift down
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_key_q <= key_i;
      in_tag_q <= entry_tag_i;
    end
    if (cmd_i.insert && do_ins) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (!gt[i]) begin
          if (i == 0 || gt[(i == 0) ? 0 : i - 1]) begin
            keys_q[i] <= in_key_q;
            tags_q[i] <= in_tag_q;
          end else begin
            keys_q[i] <= keys_q[(i == 0) ? 0 : i - 1];
            tags_q[i] <= tags_q[(i == 0) ? 0 : i - 1];
          end
        end
      end
    end
    if (cmd_i.insert) begin
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      rank_q <= RANK_RESET;
    end else begin
      if (cmd_i.insert && do_ins) cnt_q <= cnt_q + CNT_W'(1);
      if (cfg_we_i)               rank_q <= cfg_data_i;
    end
  end

  // rank zero reads as rank one
  assign rank_eff = (rank_q == '0) ? RANK_W'(1) : rank_q;
  assign rank_idx = IDX_W'(rank_eff - RANK_W'(1));
  assign win_ok   = CMP_W'(rank_eff) <= CMP_W'(cnt_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_res) begin
      res_cnt_q   <= cnt_q;
      res_valid_q <= win_ok;
      if (win_ok) begin
        res_key_q <= keys_q[rank_idx];
        res_tag_q <= tags_q[rank_idx];
      end else begin
        res_key_q <= '0;
        res_tag_q <= '0;
      end
    end
  end

  assign status_o       = status_q;
  assign entry_count_o  = res_cnt_q;
  assign winner_valid_o = res_valid_q;
  assign winner_key_o   = res_key_q;
  assign winner_tag_o   = res_tag_q;

endmodule

FILE: design/sorted_unique_rank_table.sv
// Channel  | Direction | Transfer                 | Signals
// ---------+-----------+--------------------------+----------------------------------------
// item     | in        | start high, busy low     | key_i, entry_tag_i
// result   | out       | done_o high, one cycle   | status_o, entry_count_o, winner_valid_o,
//          |           |                          | winner_key_o, winner_tag_o
// config   | in        | cfg_valid_i & cfg_ready_o| cfg_data_i (winning rank)
//
// An item goes through capture, a parallel compare-and-shift over all
// table cells, then the winner read; done_o pulses in the cycle after that.
// busy is low again in the done_o cycle, so the next item can start then.
// Reset empties the table and sets the winning rank to 2; no clearing pass.
// The result is flagged by done_o for one cycle only; the receiver cannot stall it.
module sorted_unique_rank_table
  import surt_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [KEY_W-1:0] key_i,
  input  logic [TAG_W-1:0]        entry_tag_i,
  output logic                    done_o,
  output logic [1:0]              status_o,
  output logic [CNT_W-1:0]        entry_count_o,
  output logic                    winner_valid_o,
  output logic signed [KEY_W-1:0] winner_key_o,
  output logic [TAG_W-1:0]        winner_tag_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [RANK_W-1:0]       cfg_data_i
);

  cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  surt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  surt_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .key_i          (key_i),
    .entry_tag_i    (entry_tag_i),
    .cfg_we_i       (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .status_o       (status_o),
    .entry_count_o  (entry_count_o),
    .winner_valid_o (winner_valid_o),
    .winner_key_o   (winner_key_o),
    .winner_tag_o   (winner_tag_o)
  );

endmodule
